FILE: hdl/i2c_eeprom_master_top_assert.svh
// Assertion macros for the I2C EEPROM master.
// Included by i2c_eeprom_master_top; needs a clock and an active-low reset in scope.
`ifndef I2C_EEPROM_MASTER_TOP_ASSERT_SVH
`define I2C_EEPROM_MASTER_TOP_ASSERT_SVH

// same-cycle implication
`define I2CM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("i2c eeprom master: same-cycle check failed");

// next-cycle implication
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("i2c eeprom master: next-cycle check failed");

`endif

FILE: hdl/i2cm_pkg.sv
// Shared types and constants of the I2C EEPROM master.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps

package i2cm_pkg;

    typedef enum logic [2:0] {
        KIND_TICK       = 3'd0,
        KIND_WRITE      = 3'd1,
        KIND_RAND_READ  = 3'd2,
        KIND_NEXT_BYTE  = 3'd3,
        KIND_CUR_READ   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        CFG_DEVICE_SELECT = 2'd0,
        CFG_TWO_BYTE_ADDR = 2'd1,
        CFG_HALF_BIT      = 2'd2,
        CFG_ACK_TIMEOUT   = 2'd3
    } t_cfg_index;

    localparam int unsigned CFG_WIDTH = 16;

    localparam logic [6:0]  DEVICE_SELECT_RST = 7'd80;
    localparam logic        TWO_BYTE_ADDR_RST = 1'b1;
    localparam logic [15:0] HALF_BIT_RST      = 16'd5;
    localparam logic [15:0] ACK_TIMEOUT_RST   = 16'd1000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] address;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic        sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_released;
        logic       busy_res;
        logic       need_data;
        logic       done_res;
        logic       nack_error;
        logic [7:0] read_data;
    } t_out_item;

    typedef struct packed {
        logic [6:0]  device_select;
        logic        two_byte_address;
        logic [15:0] half_bit_ticks;
        logic [15:0] ack_timeout;
    } t_cfg;

endpackage

FILE: hdl/i2cm_core.sv
// Bus sequencer of the I2C EEPROM master: one state update per accepted tick beat.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  i2cm_pkg::t_in_item i_item,
    input  i2cm_pkg::t_cfg     i_cfg,
    output i2cm_pkg::t_out_item o_result
);

    typedef enum logic [14:0] {
        PH_IDLE = 15'b000000000000001,
        PH_DONE = 15'b000000000000010,
        PH_S1   = 15'b000000000000100,
        PH_S2   = 15'b000000000001000,
        PH_S3   = 15'b000000000010000,
        PH_W1   = 15'b000000000100000,
        PH_W2   = 15'b000000001000000,
        PH_W3   = 15'b000000010000000,
        PH_ACK  = 15'b000000100000000,
        PH_WAIT = 15'b000001000000000,
        PH_R1   = 15'b000010000000000,
        PH_R2   = 15'b000100000000000,
        PH_P1   = 15'b001000000000000,
        PH_P2   = 15'b010000000000000,
        PH_P3   = 15'b100000000000000
    } t_phase;

    typedef enum logic [4:0] {
        ST_DEVW  = 5'b00001,
        ST_ADDRH = 5'b00010,
        ST_ADDRL = 5'b00100,
        ST_DATA  = 5'b01000,
        ST_DEVR  = 5'b10000
    } t_stage;

    t_phase      r_phase, n_phase;
    t_stage      r_stage, n_stage;
    logic [3:0]  r_bit_cnt, n_bit_cnt;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_tick, n_tick;
    logic [15:0] r_ack_wait, n_ack_wait;
    logic [15:0] r_addr, n_addr;
    logic [7:0]  r_data, n_data;
    logic        r_last, n_last;
    logic        r_cmd_write, n_cmd_write;
    logic        r_nack, n_nack;
    logic        r_sda_latch, n_sda_latch;

    logic [15:0] seg_len;
    logic [15:0] ack_limit;
    logic        seg_done;
    logic [15:0] seg_tick;
    logic [15:0] ack_inc;
    logic [3:0]  bit_inc;
    logic [7:0]  dev_byte;
    logic        scl;
    logic        sda;
    logic        rel;
    logic        drives;

    always_comb begin
        seg_len   = (i_cfg.half_bit_ticks == 16'd0) ? 16'd1 : i_cfg.half_bit_ticks;
        ack_limit = (i_cfg.ack_timeout == 16'd0) ? 16'd1 : i_cfg.ack_timeout;
        seg_done  = ({1'b0, r_tick} + 17'd1) >= {1'b0, seg_len};
        seg_tick  = seg_done ? 16'd0 : r_tick + 16'd1;
        ack_inc   = r_ack_wait + 16'd1;
        bit_inc   = r_bit_cnt + 4'd1;
        dev_byte  = {i_cfg.device_select, 1'b0};
    end

    // line levels from the current phase
    always_comb begin
        scl    = 1'b0;
        sda    = r_sda_latch;
        rel    = 1'b0;
        drives = 1'b1;
        unique case (r_phase)
            PH_S1:  begin scl = 1'b0; sda = 1'b1; end
            PH_S2:  begin scl = 1'b1; sda = 1'b1; end
            PH_S3:  begin scl = 1'b1; sda = 1'b0; end
            PH_W1:  begin scl = 1'b0; sda = r_shift[7]; end
            PH_W2:  begin scl = 1'b1; sda = r_shift[7]; end
            PH_W3:  begin scl = 1'b0; sda = r_shift[7]; end
            PH_ACK: begin scl = 1'b1; rel = 1'b1; drives = 1'b0; end
            PH_R1:  begin scl = 1'b1; rel = 1'b1; drives = 1'b0; end
            PH_R2:  begin scl = 1'b0; rel = 1'b1; drives = 1'b0; end
            PH_P1:  begin scl = 1'b0; sda = 1'b0; end
            PH_P2:  begin scl = 1'b1; sda = 1'b0; end
            PH_P3:  begin scl = 1'b1; sda = 1'b1; end
            default: drives = 1'b0;
        endcase
    end

    always_comb begin
        o_result.scl_out      = scl;
        o_result.sda_out      = sda;
        o_result.sda_released = rel;
        o_result.busy_res     = (r_phase != PH_IDLE) && (r_phase != PH_DONE);
        o_result.need_data    = (r_phase == PH_WAIT);
        o_result.done_res     = (r_phase == PH_DONE);
        o_result.nack_error   = (r_phase == PH_DONE) && r_nack;
        o_result.read_data    = ((r_phase == PH_DONE) && !r_nack && !r_cmd_write)
                                ? r_shift : 8'd0;
    end

    always_comb begin
        n_phase     = r_phase;
        n_stage     = r_stage;
        n_bit_cnt   = r_bit_cnt;
        n_shift     = r_shift;
        n_tick      = r_tick;
        n_ack_wait  = r_ack_wait;
        n_addr      = r_addr;
        n_data      = r_data;
        n_last      = r_last;
        n_cmd_write = r_cmd_write;
        n_nack      = r_nack;
        n_sda_latch = drives ? sda : r_sda_latch;

        unique case (r_phase)
            PH_IDLE, PH_DONE: begin
                n_phase = PH_IDLE;
                if (i_item.kind == i2cm_pkg::KIND_WRITE
                        || i_item.kind == i2cm_pkg::KIND_RAND_READ
                        || i_item.kind == i2cm_pkg::KIND_CUR_READ) begin
                    n_cmd_write = (i_item.kind == i2cm_pkg::KIND_WRITE);
                    n_nack      = 1'b0;
                    if (i_item.kind == i2cm_pkg::KIND_CUR_READ) begin
                        n_stage = ST_DEVR;
                    end else begin
                        n_stage = ST_DEVW;
                        n_addr  = i_item.address;
                    end
                    if (i_item.kind == i2cm_pkg::KIND_WRITE) begin
                        n_data = i_item.data_byte;
                        n_last = i_item.last_byte;
                    end
                    n_tick  = 16'd0;
                    n_phase = PH_S1;
                end
            end
            PH_WAIT: begin
                if (i_item.kind == i2cm_pkg::KIND_NEXT_BYTE) begin
                    n_data    = i_item.data_byte;
                    n_last    = i_item.last_byte;
                    n_stage   = ST_DATA;
                    n_shift   = i_item.data_byte;
                    n_bit_cnt = 4'd0;
                    n_tick    = 16'd0;
                    n_phase   = PH_W1;
                end
            end
            PH_S1: begin
                n_tick = seg_tick;
                if (seg_done) n_phase = PH_S2;
            end
            PH_S2: begin
                n_tick = seg_tick;
                if (seg_done) n_phase = PH_S3;
            end
            PH_S3: begin
                n_tick = seg_tick;
                if (seg_done) begin
                    n_shift   = {dev_byte[7:1], (r_stage == ST_DEVR)};
                    n_bit_cnt = 4'd0;
                    n_tick    = 16'd0;
                    n_phase   = PH_W1;
                end
            end
            PH_W1: begin
                n_tick = seg_tick;
                if (seg_done) n_phase = PH_W2;
            end
            PH_W2: begin
                n_tick = seg_tick;
                if (seg_done) n_phase = PH_W3;
            end
            PH_W3: begin
                n_tick = seg_tick;
                if (seg_done) begin
                    n_shift   = {r_shift[6:0], 1'b0};
                    n_bit_cnt = bit_inc;
                    if (bit_inc >= 4'd8) begin
                        n_ack_wait = 16'd0;
                        n_phase    = PH_ACK;
                    end else begin
                        n_phase = PH_W1;
                    end
                end
            end
            PH_ACK: begin
                if (!i_item.sda_in) begin
                    // acknowledged: pick the next byte of the sequence
                    case (r_stage)
                        ST_DEVW: begin
                            n_bit_cnt = 4'd0;
                            n_tick    = 16'd0;
                            n_phase   = PH_W1;
                            if (i_cfg.two_byte_address) begin
                                n_stage = ST_ADDRH;
                                n_shift = r_addr[15:8];
                            end else begin
                                n_stage = ST_ADDRL;
                                n_shift = r_addr[7:0];
                            end
                        end
                        ST_ADDRH: begin
                            n_stage   = ST_ADDRL;
                            n_shift   = r_addr[7:0];
                            n_bit_cnt = 4'd0;
                            n_tick    = 16'd0;
                            n_phase   = PH_W1;
                        end
                        ST_ADDRL: begin
                            n_tick = 16'd0;
                            if (r_cmd_write) begin
                                n_stage   = ST_DATA;
                                n_shift   = r_data;
                                n_bit_cnt = 4'd0;
                                n_phase   = PH_W1;
                            end else begin
                                // repeated start, then device read byte
                                n_stage = ST_DEVR;
                                n_phase = PH_S1;
                            end
                        end
                        ST_DATA: begin
                            n_tick  = 16'd0;
                            n_phase = r_last ? PH_P1 : PH_WAIT;
                        end
                        default: begin
                            n_shift   = 8'd0;
                            n_bit_cnt = 4'd0;
                            n_tick    = 16'd0;
                            n_phase   = PH_R1;
                        end
                    endcase
                end else begin
                    n_ack_wait = ack_inc;
                    if (ack_inc >= ack_limit) begin
                        n_nack  = 1'b1;
                        n_phase = PH_DONE;
                    end
                end
            end
            PH_R1: begin
                n_tick = seg_tick;
                if (seg_done) begin
                    n_shift = {r_shift[6:0], i_item.sda_in};
                    n_phase = PH_R2;
                end
            end
            PH_R2: begin
                n_tick = seg_tick;
                if (seg_done) begin
                    n_bit_cnt = bit_inc;
                    n_phase   = (bit_inc >= 4'd8) ? PH_P1 : PH_R1;
                end
            end
            PH_P1: begin
                n_tick = seg_tick;
                if (seg_done) n_phase = PH_P2;
            end
            PH_P2: begin
                n_tick = seg_tick;
                if (seg_done) n_phase = PH_P3;
            end
            PH_P3: begin
                n_tick = seg_tick;
                if (seg_done) begin
                    n_nack  = 1'b0;
                    n_phase = PH_DONE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_stage     <= ST_DEVW;
            r_bit_cnt   <= 4'd0;
            r_shift     <= 8'd0;
            r_tick      <= 16'd0;
            r_ack_wait  <= 16'd0;
            r_addr      <= 16'd0;
            r_data      <= 8'd0;
            r_last      <= 1'b0;
            r_cmd_write <= 1'b0;
            r_nack      <= 1'b0;
            r_sda_latch <= 1'b1;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_stage     <= n_stage;
            r_bit_cnt   <= n_bit_cnt;
            r_shift     <= n_shift;
            r_tick      <= n_tick;
            r_ack_wait  <= n_ack_wait;
            r_addr      <= n_addr;
            r_data      <= n_data;
            r_last      <= n_last;
            r_cmd_write <= n_cmd_write;
            r_nack      <= n_nack;
            r_sda_latch <= n_sda_latch;
        end
    end

endmodule

FILE: hdl/i2cm_out_stage.sv
// Result register of the I2C EEPROM master, with valid/ready toward the receiver.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  i2cm_pkg::t_out_item i_result,
    output logic                o_can_load,
    output logic                o_valid,
    input  logic                i_ready,
    output i2cm_pkg::t_out_item o_data
);

    logic                r_valid;
    i2cm_pkg::t_out_item r_data;

    // a held beat that is leaving this cycle frees the slot
    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: hdl/i2c_eeprom_master_top.sv
// Top level of the tick-driven I2C EEPROM master: configuration registers,
// sequencer and result register. Depends on i2cm_pkg, i2cm_core, i2cm_out_stage.
//
// Usage:
//   Each input beat on i_in_* is one bus tick and may carry a command
//   (write, random read, next write byte, current read). For every accepted
//   input beat exactly one result beat leaves on o_out_*, carrying the SCL/SDA
//   levels and status as they stood before that tick was applied.
//   The result beat is registered and valid in the cycle after its input is accepted.
//   Throughput: one beat per cycle unless stalled; the sequencer state register
//   is updated once per accepted beat by a single pass of next-state logic.
//   When the receiver stalls, the held result stays in the output register and
//   o_in_ready drops until it is taken; no tick is lost or repeated.
//   Configuration: i_cfg_we writes register i_cfg_index (0 device select,
//   1 two-byte address, 2 half-bit ticks, 3 acknowledge timeout) with the
//   low bits of i_cfg_wdata; write only while idle.
//   Reset (synchronous, active low): sequencer idle, SDA latch high, output
//   register empty, registers back to 80 / 1 / 5 / 1000.
`timescale 1ns / 1ps

module i2c_eeprom_master_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  i2cm_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output i2cm_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [i2cm_pkg::CFG_WIDTH-1:0] i_cfg_wdata
);

`include "i2c_eeprom_master_top_assert.svh"

    i2cm_pkg::t_cfg      r_cfg;
    i2cm_pkg::t_out_item core_result;
    logic                can_load;
    logic                step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_select    <= i2cm_pkg::DEVICE_SELECT_RST;
            r_cfg.two_byte_address <= i2cm_pkg::TWO_BYTE_ADDR_RST;
            r_cfg.half_bit_ticks   <= i2cm_pkg::HALF_BIT_RST;
            r_cfg.ack_timeout      <= i2cm_pkg::ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i2cm_pkg::t_cfg_index'(i_cfg_index))
                i2cm_pkg::CFG_DEVICE_SELECT: r_cfg.device_select    <= i_cfg_wdata[6:0];
                i2cm_pkg::CFG_TWO_BYTE_ADDR: r_cfg.two_byte_address <= i_cfg_wdata[0];
                i2cm_pkg::CFG_HALF_BIT:      r_cfg.half_bit_ticks   <= i_cfg_wdata[15:0];
                i2cm_pkg::CFG_ACK_TIMEOUT:   r_cfg.ack_timeout      <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = can_load;
    assign step       = i_in_valid && can_load;

    i2cm_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (i_in_data),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

    i2cm_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_result   (core_result),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (o_out_data)
    );

    // every accepted tick yields a result beat in the next cycle
    `I2CM_ASSERT_NEXT(a_tick_gives_beat, i_clk, i_rst_n, step, o_out_valid)

    // an acknowledge timeout is only reported on the done beat, with no read byte
    `I2CM_ASSERT_IMP(a_nack_on_done, i_clk, i_rst_n, o_out_valid && o_out_data.nack_error,
        o_out_data.done_res && (o_out_data.read_data == 8'd0))

    // waiting for the next write byte counts as busy, and done never overlaps busy
    `I2CM_ASSERT_IMP(a_busy_flags, i_clk, i_rst_n, o_out_valid,
        (!o_out_data.need_data || o_out_data.busy_res)
        && !(o_out_data.done_res && o_out_data.busy_res))

endmodule

FILE: dv/tb.sv
// Testbench for the tick-driven I2C EEPROM master: one input beat is one bus tick.
// Depends on i2cm_pkg and i2c_eeprom_master_top; self-checking, no external files.
`timescale 1ns / 1ps

module tb;
    import i2cm_pkg::*;

    typedef enum logic [4:0] {
        BP_IDLE, BP_DONE, BP_S1, BP_S2, BP_S3, BP_W1, BP_W2, BP_W3,
        BP_ACK, BP_WAIT, BP_R1, BP_R2, BP_P1, BP_P2, BP_P3
    } t_bus_phase;

    typedef enum logic [2:0] {
        SEL_DEVW, SEL_ADDRH, SEL_ADDRL, SEL_DATA, SEL_DEVR
    } t_byte_sel;

    localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
    localparam int STALL_LIMIT = 1000;
    localparam int LONG_HOLD = 200;

    logic                i_clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                o_in_ready;
    t_in_item            in_data = '0;
    logic                o_out_valid;
    logic                out_ready = 1'b0;
    t_out_item           o_out_data;
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_index = '0;
    logic [CFG_WIDTH-1:0] cfg_wdata = '0;

    i2c_eeprom_master_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // master model state
    t_cfg       cfg_now;
    t_bus_phase seq_phase;
    t_byte_sel  byte_sel;
    logic [3:0] bit_cnt;
    logic [7:0] shifter;
    logic [15:0] unit_cnt;
    logic [15:0] ack_cnt;
    logic [15:0] addr_q;
    logic       last_q;
    logic [2:0] cmd_q;
    logic [7:0] wbyte_q;
    logic       nack_q;
    logic       sda_q;

    t_in_item   tick_q[$];
    t_out_item  line_state_q[$];

    int  errors = 0;
    int  idle_pct = 0;
    int  src_gap = 0;
    int  sink_gap = 0;
    int  long_hold = 0;
    bit  held_once = 1'b0;
    int  stall_cnt = 0;

    function automatic void model_reset();
        cfg_now.device_select    = DEVICE_SELECT_RST;
        cfg_now.two_byte_address = TWO_BYTE_ADDR_RST;
        cfg_now.half_bit_ticks   = HALF_BIT_RST;
        cfg_now.ack_timeout      = ACK_TIMEOUT_RST;
        seq_phase = BP_IDLE;
        byte_sel  = SEL_DEVW;
        bit_cnt   = '0;
        shifter   = '0;
        unit_cnt  = '0;
        ack_cnt   = '0;
        addr_q    = '0;
        last_q    = 1'b0;
        cmd_q     = KIND_TICK;
        wbyte_q   = '0;
        nack_q    = 1'b0;
        sda_q     = 1'b1;
    endfunction

    // end of one delay unit; zero delay acts as one tick
    function automatic bit unit_done();
        int unsigned span;
        int unsigned nxt;
        span = (cfg_now.half_bit_ticks == 16'd0) ? 1 : cfg_now.half_bit_ticks;
        nxt = unit_cnt + 1;
        if (nxt >= span) begin
            unit_cnt = '0;
            return 1'b1;
        end
        unit_cnt = nxt[15:0];
        return 1'b0;
    endfunction

    function automatic void load_byte(logic [7:0] v);
        shifter   = v;
        bit_cnt   = '0;
        unit_cnt  = '0;
        seq_phase = BP_W1;
    endfunction

    function automatic void start_cond();
        unit_cnt  = '0;
        seq_phase = BP_S1;
    endfunction

    function automatic void byte_acked();
        case (byte_sel)
            SEL_DEVW: begin
                if (cfg_now.two_byte_address) begin
                    byte_sel = SEL_ADDRH;
                    load_byte(addr_q[15:8]);
                end else begin
                    byte_sel = SEL_ADDRL;
                    load_byte(addr_q[7:0]);
                end
            end
            SEL_ADDRH: begin
                byte_sel = SEL_ADDRL;
                load_byte(addr_q[7:0]);
            end
            SEL_ADDRL: begin
                if (cmd_q == KIND_WRITE) begin
                    byte_sel = SEL_DATA;
                    load_byte(wbyte_q);
                end else begin
                    // random read: repeated start, then device read byte
                    byte_sel = SEL_DEVR;
                    start_cond();
                end
            end
            SEL_DATA: begin
                unit_cnt  = '0;
                seq_phase = last_q ? BP_P1 : BP_WAIT;
            end
            default: begin
                shifter   = '0;
                bit_cnt   = '0;
                unit_cnt  = '0;
                seq_phase = BP_R1;
            end
        endcase
    endfunction

    // one bus tick: returns the line levels and status before the tick applies
    function automatic t_out_item step_master(t_in_item it);
        t_out_item   r;
        logic        scl;
        logic        sda;
        logic        rel;
        logic        drv;
        int unsigned lim;
        scl = 1'b0;
        sda = sda_q;
        rel = 1'b0;
        drv = 1'b1;
        lim = (cfg_now.ack_timeout == 16'd0) ? 1 : cfg_now.ack_timeout;
        case (seq_phase)
            BP_S1: begin scl = 1'b0; sda = 1'b1; end
            BP_S2: begin scl = 1'b1; sda = 1'b1; end
            BP_S3: begin scl = 1'b1; sda = 1'b0; end
            BP_W1, BP_W3: begin scl = 1'b0; sda = shifter[7]; end
            BP_W2: begin scl = 1'b1; sda = shifter[7]; end
            BP_ACK, BP_R1: begin scl = 1'b1; rel = 1'b1; drv = 1'b0; end
            BP_R2: begin scl = 1'b0; rel = 1'b1; drv = 1'b0; end
            BP_P1: begin scl = 1'b0; sda = 1'b0; end
            BP_P2: begin scl = 1'b1; sda = 1'b0; end
            BP_P3: begin scl = 1'b1; sda = 1'b1; end
            default: drv = 1'b0;
        endcase
        if (drv) sda_q = sda;

        r.scl_out      = scl;
        r.sda_out      = sda;
        r.sda_released = rel;
        r.busy_res     = (seq_phase != BP_IDLE) && (seq_phase != BP_DONE);
        r.need_data    = (seq_phase == BP_WAIT);
        r.done_res     = (seq_phase == BP_DONE);
        r.nack_error   = (seq_phase == BP_DONE) && nack_q;
        r.read_data    = (seq_phase == BP_DONE && !nack_q && cmd_q != KIND_WRITE) ?
                         shifter : 8'h00;

        case (seq_phase)
            BP_IDLE, BP_DONE: begin
                seq_phase = BP_IDLE;
                if (it.kind == KIND_WRITE || it.kind == KIND_RAND_READ ||
                    it.kind == KIND_CUR_READ) begin
                    cmd_q  = it.kind;
                    nack_q = 1'b0;
                    if (it.kind == KIND_CUR_READ) begin
                        byte_sel = SEL_DEVR;
                    end else begin
                        byte_sel = SEL_DEVW;
                        addr_q   = it.address;
                    end
                    if (it.kind == KIND_WRITE) begin
                        wbyte_q = it.data_byte;
                        last_q  = it.last_byte;
                    end
                    start_cond();
                end
            end
            BP_WAIT: begin
                if (it.kind == KIND_NEXT_BYTE) begin
                    wbyte_q  = it.data_byte;
                    last_q   = it.last_byte;
                    byte_sel = SEL_DATA;
                    load_byte(it.data_byte);
                end
            end
            BP_S1: if (unit_done()) seq_phase = BP_S2;
            BP_S2: if (unit_done()) seq_phase = BP_S3;
            BP_S3: if (unit_done()) load_byte({cfg_now.device_select, byte_sel == SEL_DEVR});
            BP_W1: if (unit_done()) seq_phase = BP_W2;
            BP_W2: if (unit_done()) seq_phase = BP_W3;
            BP_W3: begin
                if (unit_done()) begin
                    shifter = shifter << 1;
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= 4'd8) begin
                        ack_cnt   = '0;
                        seq_phase = BP_ACK;
                    end else begin
                        seq_phase = BP_W1;
                    end
                end
            end
            BP_ACK: begin
                if (!it.sda_in) begin
                    byte_acked();
                end else begin
                    ack_cnt = ack_cnt + 16'd1;
                    // no stop condition on a timed-out acknowledge
                    if (ack_cnt >= lim) begin
                        nack_q    = 1'b1;
                        seq_phase = BP_DONE;
                    end
                end
            end
            BP_R1: begin
                if (unit_done()) begin
                    shifter   = {shifter[6:0], it.sda_in};
                    seq_phase = BP_R2;
                end
            end
            BP_R2: begin
                if (unit_done()) begin
                    bit_cnt   = bit_cnt + 4'd1;
                    seq_phase = (bit_cnt >= 4'd8) ? BP_P1 : BP_R1;
                end
            end
            BP_P1: if (unit_done()) seq_phase = BP_P2;
            BP_P2: if (unit_done()) seq_phase = BP_P3;
            BP_P3: begin
                if (unit_done()) begin
                    nack_q    = 1'b0;
                    seq_phase = BP_DONE;
                end
            end
            default: seq_phase = BP_IDLE;
        endcase
        return r;
    endfunction

    function automatic void emit(t_in_item it);
        line_state_q.push_back(step_master(it));
        tick_q.push_back(it);
    endfunction

    function automatic void put(logic [2:0] k, logic [15:0] a, logic [7:0] d, logic l, logic s);
        t_in_item it;
        it.kind      = k;
        it.address   = a;
        it.data_byte = d;
        it.last_byte = l;
        it.sda_in    = s;
        emit(it);
    endfunction

    // random tick shaped by where the sequencer stands; quiet mode only steers it home
    function automatic t_in_item rand_item(int cmd_pct, int nack_pct, bit quiet);
        t_in_item it;
        it.kind      = 3'($urandom_range(7));
        it.address   = 16'($urandom);
        it.data_byte = 8'($urandom);
        it.last_byte = 1'($urandom_range(1));
        it.sda_in    = 1'($urandom_range(1));
        case (seq_phase)
            BP_IDLE, BP_DONE: begin
                if (quiet) begin
                    case ($urandom_range(4))
                        0: it.kind = KIND_TICK;
                        1: it.kind = KIND_NEXT_BYTE;
                        default: it.kind = 3'($urandom_range(7, 5));
                    endcase
                end else if ($urandom_range(99) < cmd_pct) begin
                    case ($urandom_range(2))
                        0: it.kind = KIND_WRITE;
                        1: it.kind = KIND_RAND_READ;
                        default: it.kind = KIND_CUR_READ;
                    endcase
                end
            end
            BP_WAIT: begin
                if (quiet) begin
                    it.kind      = KIND_NEXT_BYTE;
                    it.last_byte = 1'b1;
                end else if ($urandom_range(99) < 85) begin
                    it.kind = KIND_NEXT_BYTE;
                end
            end
            BP_ACK: begin
                it.sda_in = quiet ? 1'b0 : ($urandom_range(99) < nack_pct);
                if (quiet || $urandom_range(99) < 80) it.kind = KIND_TICK;
            end
            default: begin
                // commands while busy are ignored but still offered now and then
                if (quiet || $urandom_range(99) < 80) it.kind = KIND_TICK;
            end
        endcase
        return it;
    endfunction

    function automatic void advance(t_bus_phase stop);
        while (seq_phase != stop && seq_phase != BP_IDLE) emit(rand_item(0, 0, 1'b1));
    endfunction

    function automatic t_cfg cfg_of(int dev, int two, int hbt, int ato);
        t_cfg c;
        c.device_select    = 7'(dev);
        c.two_byte_address = 1'(two);
        c.half_bit_ticks   = 16'(hbt);
        c.ack_timeout      = 16'(ato);
        return c;
    endfunction

    // unused upper bits carry noise; the block must ignore them
    task automatic set_regs(t_cfg c);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_DEVICE_SELECT;
        cfg_wdata <= (16'($urandom) & 16'hFF80) | 16'(c.device_select);
        @(posedge i_clk);
        cfg_index <= CFG_TWO_BYTE_ADDR;
        cfg_wdata <= (16'($urandom) & 16'hFFFE) | 16'(c.two_byte_address);
        @(posedge i_clk);
        cfg_index <= CFG_HALF_BIT;
        cfg_wdata <= c.half_bit_ticks;
        @(posedge i_clk);
        cfg_index <= CFG_ACK_TIMEOUT;
        cfg_wdata <= c.ack_timeout;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        cfg_now = c;
        @(posedge i_clk);
    endtask

    task automatic settle();
        while (line_state_q.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    task automatic run_phase(t_cfg c, int n, int idle, int nack, bit keep_busy);
        settle();
        set_regs(c);
        idle_pct = idle;
        repeat (n) emit(rand_item(60, nack, 1'b0));
        if (!keep_busy) advance(BP_IDLE);
    endtask

    initial begin
        model_reset();
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;

        // directed: zero delay, zero timeout, top device address
        set_regs(cfg_of(127, 1, 0, 0));
        idle_pct = 25;
        put(KIND_NEXT_BYTE, 16'h1234, 8'hA5, 1'b1, 1'b0);
        put(KIND_UNUSED_HI, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
        put(KIND_TICK, 16'h0000, 8'h00, 1'b0, 1'b0);
        put(KIND_WRITE, 16'hFFFF, 8'hFF, 1'b0, 1'b0);
        put(KIND_CUR_READ, 16'h0000, 8'h00, 1'b0, 1'b0);
        advance(BP_WAIT);
        put(KIND_TICK, 16'h0000, 8'h00, 1'b0, 1'b1);
        put(KIND_RAND_READ, 16'h5A5A, 8'h00, 1'b0, 1'b1);
        put(KIND_NEXT_BYTE, 16'h0000, 8'h00, 1'b1, 1'b0);
        advance(BP_IDLE);
        put(KIND_RAND_READ, 16'h0000, 8'h00, 1'b0, 1'b0);
        advance(BP_IDLE);
        put(KIND_CUR_READ, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
        advance(BP_IDLE);
        put(KIND_WRITE, 16'h8001, 8'h7E, 1'b1, 1'b0);
        advance(BP_ACK);
        put(KIND_TICK, 16'h0000, 8'h00, 1'b0, 1'b1);
        advance(BP_IDLE);

        run_phase(cfg_of($urandom_range(127), 0, 1, 3), 300, 20, 10, 1'b0);
        run_phase(cfg_of(0, 1, 0, 1), 300, 30, 5, 1'b0);
        run_phase(cfg_of(127, 1, 2, 1000), 300, 15, 10, 1'b0);
        run_phase(cfg_of($urandom_range(127), 0, 3, 65535), 250, 0, 10, 1'b0);
        run_phase(cfg_of($urandom_range(127), 1, 1, 2), 300, 0, 30, 1'b0);
        // longest delay unit: the block stays mid-sequence to the end
        run_phase(cfg_of($urandom_range(127), $urandom_range(1), 65535, 5), 120, 0, 0, 1'b1);

        settle();
        if (errors == 0 && line_state_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // sender: holds a beat until it is taken
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            src_gap  <= 0;
        end else if (!in_valid || o_in_ready) begin
            if (src_gap != 0) begin
                src_gap  <= src_gap - 1;
                in_valid <= 1'b0;
            end else if (tick_q.size() != 0) begin
                if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
                    src_gap  <= $urandom_range(8);
                    in_valid <= 1'b0;
                end else begin
                    in_data  <= tick_q.pop_front();
                    in_valid <= 1'b1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stall bursts plus one long hold to back the block up
    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (long_hold != 0) begin
            long_hold <= long_hold - 1;
            out_ready <= 1'b0;
        end else if (!held_once && tick_q.size() > 120) begin
            held_once <= 1'b1;
            long_hold <= LONG_HOLD;
            out_ready <= 1'b0;
        end else if (sink_gap != 0) begin
            sink_gap  <= sink_gap - 1;
            out_ready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            sink_gap  <= $urandom_range(8);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic void flag_field(string name, logic [7:0] e, logic [7:0] a);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
        errors++;
    endfunction

    always @(posedge i_clk) begin
        t_out_item e;
        if (rst_n && o_out_valid && out_ready) begin
            if (line_state_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, got %0h", $time, o_out_data);
                errors++;
            end else begin
                e = line_state_q.pop_front();
                if (o_out_data.scl_out !== e.scl_out)
                    flag_field("scl_out", e.scl_out, o_out_data.scl_out);
                if (o_out_data.sda_out !== e.sda_out)
                    flag_field("sda_out", e.sda_out, o_out_data.sda_out);
                if (o_out_data.sda_released !== e.sda_released)
                    flag_field("sda_released", e.sda_released, o_out_data.sda_released);
                if (o_out_data.busy_res !== e.busy_res)
                    flag_field("busy_res", e.busy_res, o_out_data.busy_res);
                if (o_out_data.need_data !== e.need_data)
                    flag_field("need_data", e.need_data, o_out_data.need_data);
                if (o_out_data.done_res !== e.done_res)
                    flag_field("done_res", e.done_res, o_out_data.done_res);
                if (o_out_data.nack_error !== e.nack_error)
                    flag_field("nack_error", e.nack_error, o_out_data.nack_error);
                if (o_out_data.read_data !== e.read_data)
                    flag_field("read_data", e.read_data, o_out_data.read_data);
            end
        end
    end

    // watchdog: any beat or register write counts as progress
    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || cfg_we || !rst_n) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

endmodule
